FILE: design/rgbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rgbe_pkg;

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_HDR2 = 3'd2,
      PH_HDR3 = 3'd3,
      PH_CODE = 3'd4,
      PH_RUN  = 3'd5,
      PH_LIT  = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_CONV,
      ST_EMIT,
      ST_TAIL
   } seq_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_LEGACY  = 2'd1,
      STATUS_OVERRUN = 2'd2
   } status_type;

   localparam logic [7:0] HDR_MAGIC   = 8'd2;
   localparam logic [7:0] RUN_THRESH  = 8'd128;
   localparam logic [6:0] COUNT_MASK  = 7'd127;
   localparam int unsigned MIN_WIDTH  = 8;

   // exact float of m * 2^(e-136); zero for m==0 or e==0
   function automatic logic [31:0] single_bits(input logic [7:0] m, input logic [7:0] e);
      logic [2:0]  p;
      logic signed [9:0] be;
      logic [31:0] r;
      p = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (m[i]) p = 3'(i);
      end
      be = 10'(signed'({7'd0, p})) + 10'(signed'({2'd0, e})) - 10'sd9;
      if (m == 8'd0 || e == 8'd0) begin
         r = 32'd0;
      end else if (be >= 10'sd1) begin
         r = {1'b0, be[7:0], 23'(({15'd0, m} << (5'd23 - {2'd0, p})) & 23'h7FFFFF)};
      end else begin
         r = 32'({24'd0, m} << ({1'b0, e} + 9'd13));
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: design/rgbe_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rgbe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] compressed_byte;
   modport source (output valid, output compressed_byte, input ready);
   modport sink   (input valid, input compressed_byte, output ready);
endinterface

interface rgbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_index;
   logic [31:0] first_red;
   logic [31:0] first_green;
   logic [31:0] first_blue;
   logic        second_valid;
   logic [31:0] second_red;
   logic [31:0] second_green;
   logic [31:0] second_blue;
   logic        line_done;
   logic [1:0]  status;
   modport source (output valid, output pixel_index, output first_red, output first_green,
                   output first_blue, output second_valid, output second_red,
                   output second_green, output second_blue, output line_done,
                   output status, input ready);
   modport sink   (input valid, input pixel_index, input first_red, input first_green,
                   input first_blue, input second_valid, input second_red,
                   input second_green, input second_blue, input line_done,
                   input status, output ready);
endinterface

interface rgbe_csr_if;
   logic        valid;
   logic        ready;
   logic [12:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/rgbe_scanline_rle_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Header and code bytes finish in the idle state; a zero-count literal passes through the
// tail state, a legacy header the emit state. Mantissa byte: per value a read, then write.
// Exponent byte: per value a read, then convert; a pair leaves when output is free.
// Close-out adds a tail step per odd-pixel or overrun result; dropped positions a step each.
// Throughput: one request at a time, ready only while idle; output stalls hold the sequencer.
// Reset (synchronous, active high) returns to header wait, width 8; line store is not cleared.
module rgbe_scanline_rle_decoder_unit #(
   parameter int MAX_LINE_WIDTH = 4096
) (
   input wire logic    clock,
   input wire logic    reset,
   rgbe_req_if.sink    req,
   rgbe_rsp_if.source  rsp,
   rgbe_csr_if.sink    csr
);
   localparam int AW = $clog2(MAX_LINE_WIDTH);
   localparam int PW = $clog2(MAX_LINE_WIDTH + 1);

   // registers
   rgbe_pkg::phase_type  phase_ff, phase_in;
   rgbe_pkg::seq_type    seq_ff, seq_in;
   logic [1:0]           plane_ff, plane_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [7:0]           rem_ff, rem_in;
   logic [12:0]          width_ff;
   logic [7:0]           byte_ff, byte_in;
   logic [7:0]           count_ff, count_in;     // values still to write this request
   logic                 drop_ff, drop_in;
   logic                 nres_ff, nres_in;       // a result was emitted this request
   logic                 half_ff, half_in;       // first pixel held
   logic [11:0]          pidx_ff, pidx_in;
   logic [95:0]          pa_ff, pa_in;
   logic                 ovalid_ff, ovalid_in;
   logic                 osec_ff, osec_in, olend_ff, olend_in;
   logic [1:0]           ostat_ff, ostat_in;
   logic [11:0]          oidx_ff, oidx_in;
   logic [95:0]          oa_ff, oa_in, ob_ff, ob_in;

   // width clamp
   logic [PW-1:0] cur_w;
   always_comb begin
      if (width_ff < 13'(rgbe_pkg::MIN_WIDTH)) cur_w = PW'(rgbe_pkg::MIN_WIDTH);
      else if ({19'd0, width_ff} > 32'(MAX_LINE_WIDTH)) cur_w = PW'(MAX_LINE_WIDTH);
      else cur_w = PW'(width_ff);
   end

   // line store
   logic          wr_en;
   logic [23:0]   wr_data, rd_data;
   logic [AW-1:0] addr;
   assign addr = pos_ff[AW-1:0];
   rgbe_ram #(.WIDTH(24), .DEPTH(MAX_LINE_WIDTH)) u_store (
      .clock, .wr_en, .wr_addr(addr), .wr_data, .rd_addr(addr), .rd_data
   );

   wire in_range = pos_ff < cur_w;
   wire req_fire = req.valid && req.ready;
   wire rsp_fire = rsp.valid && rsp.ready;
   wire out_free = !ovalid_ff || rsp.ready;

   assign req.ready = (seq_ff == rgbe_pkg::ST_IDLE);
   assign csr.ready = 1'b1;

   // sequencer outputs: mantissa planes write back in the read-data cycle
   always_comb begin
      wr_en = (seq_ff == rgbe_pkg::ST_READ) && (plane_ff != 2'd3);
   end

   always_comb begin
      wr_data = rd_data;
      unique case (plane_ff)
         2'd0:    wr_data[7:0]   = byte_ff;
         2'd1:    wr_data[15:8]  = byte_ff;
         default: wr_data[23:16] = byte_ff;
      endcase
   end

   // shared converter on one read word
   logic [95:0] conv;
   assign conv = {rgbe_pkg::single_bits(rd_data[23:16], byte_ff),
                  rgbe_pkg::single_bits(rd_data[15:8], byte_ff),
                  rgbe_pkg::single_bits(rd_data[7:0], byte_ff)};

   // sequencer
   always_comb begin
      phase_in = phase_ff; seq_in = seq_ff; plane_in = plane_ff; pos_in = pos_ff;
      rem_in = rem_ff; byte_in = byte_ff; count_in = count_ff; drop_in = drop_ff;
      nres_in = nres_ff; half_in = half_ff; pidx_in = pidx_ff;
      pa_in = pa_ff;
      ovalid_in = ovalid_ff && !rsp_fire;
      osec_in = osec_ff; olend_in = olend_ff; ostat_in = ostat_ff; oidx_in = oidx_ff;
      oa_in = oa_ff; ob_in = ob_ff;
      unique case (seq_ff)
         rgbe_pkg::ST_IDLE: begin
            if (req_fire) begin
               byte_in = req.compressed_byte;
               drop_in = 1'b0; nres_in = 1'b0; half_in = 1'b0;
               unique case (phase_ff)
                  rgbe_pkg::PH_HDR1: phase_in = rgbe_pkg::PH_HDR2;
                  rgbe_pkg::PH_HDR2: phase_in = rgbe_pkg::PH_HDR3;
                  rgbe_pkg::PH_HDR3: begin
                     phase_in = rgbe_pkg::PH_CODE; plane_in = 2'd0;
                     pos_in = '0; rem_in = 8'd0;
                  end
                  rgbe_pkg::PH_CODE: begin
                     if (req.compressed_byte > rgbe_pkg::RUN_THRESH) begin
                        rem_in = {1'b0, req.compressed_byte[6:0] & rgbe_pkg::COUNT_MASK};
                        phase_in = rgbe_pkg::PH_RUN;
                     end else if (req.compressed_byte == 8'd0) begin
                        count_in = 8'd0; seq_in = rgbe_pkg::ST_TAIL;
                     end else begin
                        rem_in = req.compressed_byte; phase_in = rgbe_pkg::PH_LIT;
                     end
                  end
                  rgbe_pkg::PH_RUN: begin
                     count_in = rem_ff; rem_in = 8'd0; seq_in = rgbe_pkg::ST_WRITE;
                  end
                  rgbe_pkg::PH_LIT: begin
                     count_in = 8'd1;
                     rem_in = (rem_ff != 8'd0) ? rem_ff - 8'd1 : 8'd0;
                     seq_in = rgbe_pkg::ST_WRITE;
                  end
                  default: begin
                     if (req.compressed_byte == rgbe_pkg::HDR_MAGIC) begin
                        phase_in = rgbe_pkg::PH_HDR1;
                     end else begin
                        // legacy header: one status result
                        seq_in = rgbe_pkg::ST_EMIT;
                     end
                  end
               endcase
            end
         end
         rgbe_pkg::ST_WRITE: begin
            // decide next value of this request
            if (count_ff == 8'd0) begin
               seq_in = rgbe_pkg::ST_TAIL;
            end else if (!in_range) begin
               drop_in = 1'b1; count_in = count_ff - 8'd1;
            end else begin
               seq_in = rgbe_pkg::ST_READ;
            end
         end
         rgbe_pkg::ST_READ: begin
            // read data valid now
            if (plane_ff != 2'd3) begin
               pos_in = pos_ff + PW'(1);
               count_in = count_ff - 8'd1;
               seq_in = rgbe_pkg::ST_WRITE;
            end else begin
               seq_in = rgbe_pkg::ST_CONV;
            end
         end
         rgbe_pkg::ST_CONV: begin
            if (!half_ff) begin
               pa_in = conv; pidx_in = 12'(pos_ff); half_in = 1'b1;
               pos_in = pos_ff + PW'(1); count_in = count_ff - 8'd1;
               seq_in = rgbe_pkg::ST_WRITE;
            end else if (out_free) begin
               ovalid_in = 1'b1; oidx_in = pidx_ff; oa_in = pa_ff; ob_in = conv;
               osec_in = 1'b1; ostat_in = rgbe_pkg::STATUS_OK;
               // last value of a code that fills the line: this pair ends it
               olend_in = (count_ff == 8'd1) && ((pos_ff + PW'(1)) >= cur_w) &&
                          plane_ff == 2'd3 &&
                          (phase_ff == rgbe_pkg::PH_RUN ||
                           (phase_ff == rgbe_pkg::PH_LIT && rem_ff == 8'd0));
               nres_in = 1'b1; half_in = 1'b0;
               pos_in = pos_ff + PW'(1); count_in = count_ff - 8'd1;
               seq_in = rgbe_pkg::ST_WRITE;
            end
         end
         rgbe_pkg::ST_TAIL: begin
            // flush odd pixel, then overrun, then line end
            if (out_free) begin
               if (half_ff) begin
                  ovalid_in = 1'b1; oidx_in = pidx_ff; oa_in = pa_ff; ob_in = '0;
                  osec_in = 1'b0; ostat_in = rgbe_pkg::STATUS_OK; nres_in = 1'b1;
                  half_in = 1'b0;
                  olend_in = !drop_ff && (pos_ff >= cur_w) && plane_ff == 2'd3 &&
                             (phase_ff == rgbe_pkg::PH_RUN ||
                              (phase_ff == rgbe_pkg::PH_LIT && rem_ff == 8'd0));
                  if (olend_in) begin
                     pos_in = '0; plane_in = 2'd0; phase_in = rgbe_pkg::PH_HDR0;
                     seq_in = rgbe_pkg::ST_IDLE;
                  end
               end else if (drop_ff) begin
                  ovalid_in = 1'b1; oidx_in = '0; oa_in = '0; ob_in = '0;
                  osec_in = 1'b0; ostat_in = rgbe_pkg::STATUS_OVERRUN; nres_in = 1'b1;
                  drop_in = 1'b0;
                  olend_in = (pos_ff >= cur_w) && plane_ff == 2'd3 &&
                             (phase_ff == rgbe_pkg::PH_RUN || phase_ff == rgbe_pkg::PH_CODE ||
                              (phase_ff == rgbe_pkg::PH_LIT && rem_ff == 8'd0));
                  if (olend_in) begin
                     pos_in = '0; plane_in = 2'd0; phase_in = rgbe_pkg::PH_HDR0;
                     seq_in = rgbe_pkg::ST_IDLE;
                  end
               end else begin
                  seq_in = rgbe_pkg::ST_IDLE;
                  if (phase_ff == rgbe_pkg::PH_RUN || phase_ff == rgbe_pkg::PH_CODE ||
                      (phase_ff == rgbe_pkg::PH_LIT && rem_ff == 8'd0)) begin
                     phase_in = rgbe_pkg::PH_CODE;
                     if (pos_ff >= cur_w) begin
                        pos_in = '0;
                        if (plane_ff == 2'd3) begin
                           plane_in = 2'd0; phase_in = rgbe_pkg::PH_HDR0;
                           if (!nres_ff) begin
                              ovalid_in = 1'b1; oidx_in = '0; oa_in = '0; ob_in = '0;
                              osec_in = 1'b0; ostat_in = rgbe_pkg::STATUS_OK;
                              olend_in = 1'b1;
                           end
                        end else begin
                           plane_in = plane_ff + 2'd1;
                        end
                     end
                  end
               end
            end
         end
         rgbe_pkg::ST_EMIT: begin
            if (out_free) begin
               ovalid_in = 1'b1; oidx_in = '0; oa_in = '0; ob_in = '0; osec_in = 1'b0;
               ostat_in = rgbe_pkg::STATUS_LEGACY; olend_in = 1'b1;
               phase_in = rgbe_pkg::PH_HDR0; seq_in = rgbe_pkg::ST_IDLE;
            end
         end
         default: seq_in = rgbe_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rgbe_pkg::PH_HDR0; seq_ff <= rgbe_pkg::ST_IDLE;
         plane_ff <= 2'd0; pos_ff <= '0; rem_ff <= 8'd0; width_ff <= 13'd8;
         ovalid_ff <= 1'b0; half_ff <= 1'b0; drop_ff <= 1'b0;
         nres_ff <= 1'b0; count_ff <= 8'd0;
      end else begin
         phase_ff <= phase_in; seq_ff <= seq_in; plane_ff <= plane_in; pos_ff <= pos_in;
         rem_ff <= rem_in; ovalid_ff <= ovalid_in; half_ff <= half_in; drop_ff <= drop_in;
         nres_ff <= nres_in; count_ff <= count_in;
         if (csr.valid && csr.ready) width_ff <= csr.data;
      end
      byte_ff <= byte_in; pidx_ff <= pidx_in; pa_ff <= pa_in;
      osec_ff <= osec_in; olend_ff <= olend_in; ostat_ff <= ostat_in; oidx_ff <= oidx_in;
      oa_ff <= oa_in; ob_ff <= ob_in;
   end

   assign rsp.valid        = ovalid_ff;
   assign rsp.pixel_index  = oidx_ff;
   assign rsp.first_red    = oa_ff[31:0];
   assign rsp.first_green  = oa_ff[63:32];
   assign rsp.first_blue   = oa_ff[95:64];
   assign rsp.second_valid = osec_ff;
   assign rsp.second_red   = ob_ff[31:0];
   assign rsp.second_green = ob_ff[63:32];
   assign rsp.second_blue  = ob_ff[95:64];
   assign rsp.line_done    = olend_ff;
   assign rsp.status       = ostat_ff;
endmodule
`default_nettype wire

FILE: design/rgbe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rgbe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
